// File: hw/rtl/ierc_pkg.sv
// package for the input event to rc channel converter
// holds sizes, codes, sequencer states and the code lookup functions; no dependencies
`default_nettype none

package ierc_pkg;

  localparam int NumAxes     = 5;
  localparam int NumChannels = 16;
  localparam int ChanIdxW    = $clog2(NumChannels);
  localparam int ChanValW    = 11;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;
  localparam int HalfW       = 16;
  localparam int ValueW      = 32;
  localparam int TypeW       = 5;
  localparam int CodeW       = 10;

  // integer divide 1000 / span, one quotient bit per step
  localparam int DivSteps  = 10;
  localparam int DivCntW   = $clog2(DivSteps);

  localparam logic [ChanValW-1:0] ChanLow  = ChanValW'(1000);
  localparam logic [ChanValW-1:0] ChanHigh = ChanValW'(2000);
  localparam logic [DivSteps-1:0] DivDividend = DivSteps'(1000);

  localparam logic [CfgDataW-1:0] RangeReset = 32'h03E8_0000;

  localparam logic [TypeW-1:0] EvtKey = TypeW'(1);
  localparam logic [TypeW-1:0] EvtAbs = TypeW'(3);

  // buttons occupy codes 0x120..0x12b
  localparam logic [CodeW-5:0] ButtonBase = 6'h12;
  localparam logic [3:0]       ButtonLast = 4'hB;

  localparam logic [ChanIdxW-1:0] LastChannel = ChanIdxW'(NumChannels - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_AX_PREP,
    ST_AX_DIV,
    ST_AX_MUL,
    ST_KEY_RD,
    ST_KEY_WR
  } state_t;

  typedef struct packed {
    logic                hit;
    logic [ChanIdxW-1:0] ch;
  } button_map_t;

  // absolute axis code -> axis channel (codes 0..4)
  function automatic logic [ChanIdxW-1:0] axis_of_code(input logic [2:0] code);
    logic [ChanIdxW-1:0] ch;
    case (code)
      3'd0: ch = ChanIdxW'(3);
      3'd1: ch = ChanIdxW'(2);
      3'd2: ch = ChanIdxW'(0);
      3'd3: ch = ChanIdxW'(1);
      default: ch = ChanIdxW'(4);
    endcase
    return ch;
  endfunction

  // button offset from 0x120 -> button channel, offset 7 has no channel
  function automatic button_map_t chan_of_button(input logic [3:0] off);
    button_map_t m;
    m.hit = 1'b1;
    case (off)
      4'd0:  m.ch = ChanIdxW'(5);
      4'd1:  m.ch = ChanIdxW'(6);
      4'd2:  m.ch = ChanIdxW'(7);
      4'd3:  m.ch = ChanIdxW'(8);
      4'd4:  m.ch = ChanIdxW'(9);
      4'd5:  m.ch = ChanIdxW'(11);
      4'd6:  m.ch = ChanIdxW'(10);
      4'd8:  m.ch = ChanIdxW'(14);
      4'd9:  m.ch = ChanIdxW'(15);
      4'd10: m.ch = ChanIdxW'(12);
      4'd11: m.ch = ChanIdxW'(13);
      default: begin
        m.hit = 1'b0;
        m.ch  = '0;
      end
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/input_event_to_rc_channels.sv
// top level of the input event to rc channel converter
// depends on ierc_pkg and ierc_ram
`default_nettype none

// Keeps sixteen rc channel values (axes roll, pitch, throttle, yaw, aux on
// channels 0..4, buttons on 5..15), all 1000 after reset. A request with
// func=0 is an input event: an absolute axis event on codes 0..4 clamps the
// value to the axis range and stores (v-min)*(1000/(max-min))+1000, or 1000
// when max<=min; a key press on a mapped button code toggles that channel
// between 1000 and 2000. A request with func=1 emits all sixteen channels in
// index order, last_channel marking channel 15. One request at a time: an
// axis event clamps, runs ten steps of a shared restoring subtract/compare
// divider, then multiplies and writes, and skips the divide when max<=min;
// a key event reads and then writes its channel, an ignored event is dropped
// on accept, and a tick reads each channel through the registered read of
// the channel ram, holding while the output stalls. The output register lets
// a new request be taken while the last channel still waits. Range registers
// are written at cfg_index 0..4 (bits 15..0 signed min, bits 31..16 signed
// max); other indexes are dropped.
// Configuration is to be written only while the block is idle.
module input_event_to_rc_channels (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input requests
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_func,
  input  wire logic [ierc_pkg::TypeW-1:0]       in_event_type,
  input  wire logic [ierc_pkg::CodeW-1:0]       in_event_code,
  input  wire logic signed [ierc_pkg::ValueW-1:0] in_event_value,
  // channel results
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ierc_pkg::ChanIdxW-1:0]         out_channel_index,
  output logic [ierc_pkg::ChanValW-1:0]         out_channel_value,
  output logic                                  out_last_channel,
  // range register writes
  input  wire logic                             cfg_we,
  input  wire logic [ierc_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [ierc_pkg::CfgDataW-1:0]    cfg_wdata
);

  import ierc_pkg::*;

  // sequencer
  state_t state_r, state_nxt;

  // range registers, one per axis
  logic [CfgDataW-1:0] range_r [NumAxes];

  // per-channel written flags; an unwritten channel reads as 1000
  logic [NumChannels-1:0] vld_r, vld_nxt;
  logic                   rd_vld_r;

  // channel pointer shared by tick, axis and key paths
  logic [ChanIdxW-1:0] idx_r, idx_nxt;
  logic                rd_ok_r, rd_ok_nxt;

  // axis datapath
  logic signed [ValueW-1:0] value_r, value_nxt;
  logic [HalfW-1:0]         span_r, span_nxt;
  logic [HalfW-1:0]         d_r, d_nxt;
  logic [HalfW-1:0]         rem_r, rem_nxt;
  logic [DivSteps-1:0]      q_r, q_nxt;
  logic [DivSteps-1:0]      dvd_r, dvd_nxt;
  logic [DivCntW-1:0]       div_cnt_r, div_cnt_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [ChanIdxW-1:0] out_index_r, out_index_nxt;
  logic [ChanValW-1:0] out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  // channel ram ports
  logic                ram_we;
  logic [ChanValW-1:0] ram_wdata;
  logic [ChanValW-1:0] ram_rdata;

  // request decode
  logic        in_acc;
  logic        is_abs, is_key;
  button_map_t btn;

  // axis prep
  logic [CfgDataW-1:0]      rng;
  logic signed [ValueW-1:0] lo_ext, hi_ext, v_clamp;
  logic signed [ValueW-1:0] d_full, span_full;
  logic                     empty_rng;

  // divider step, the shared subtract/compare unit
  logic [HalfW:0] rem_sh;
  logic [HalfW:0] rem_sub;
  logic           div_ge;

  // multiply
  logic [HalfW+DivSteps-1:0] prod;

  // tick and key helpers
  logic                out_free;
  logic                tick_load;
  logic [ChanValW-1:0] rd_value;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign is_abs = (in_event_type == EvtAbs) && (in_event_code < CodeW'(NumAxes));
  assign btn    = chan_of_button(in_event_code[3:0]);
  assign is_key = (in_event_type == EvtKey) && (in_event_code[CodeW-1:4] == ButtonBase)
                  && (in_event_code[3:0] <= ButtonLast) && (in_event_value != '0) && btn.hit;

  assign out_free  = !out_valid_r || !out_stall;
  assign tick_load = (state_r == ST_TICK) && rd_ok_r && out_free;
  assign rd_value  = rd_vld_r ? ram_rdata : ChanLow;

  // range of the selected axis; idx_r holds 0..4 here
  assign rng       = range_r[idx_r[CfgIdxW-1:0]];
  assign lo_ext    = ValueW'(signed'(rng[HalfW-1:0]));
  assign hi_ext    = ValueW'(signed'(rng[CfgDataW-1:HalfW]));
  assign empty_rng = (hi_ext <= lo_ext);

  always_comb begin
    if (value_r < lo_ext) begin
      v_clamp = lo_ext;
    end else if (value_r > hi_ext) begin
      v_clamp = hi_ext;
    end else begin
      v_clamp = value_r;
    end
  end

  // both differences fit 16 bits unsigned once the range is non-empty
  assign d_full    = v_clamp - lo_ext;
  assign span_full = hi_ext - lo_ext;

  assign rem_sh  = {rem_r, dvd_r[DivSteps-1]};
  assign div_ge  = (rem_sh >= {1'b0, span_r});
  assign rem_sub = rem_sh - {1'b0, span_r};

  assign prod = (HalfW+DivSteps)'(d_r) * (HalfW+DivSteps)'(q_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func) begin
            state_nxt = ST_TICK;
          end else if (is_abs) begin
            state_nxt = ST_AX_PREP;
          end else if (is_key) begin
            state_nxt = ST_KEY_RD;
          end
        end
      end
      ST_TICK: begin
        if (tick_load && (idx_r == LastChannel)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_AX_PREP: begin
        // an empty range skips the divide with a zero quotient
        state_nxt = empty_rng ? ST_AX_MUL : ST_AX_DIV;
      end
      ST_AX_DIV: begin
        if (div_cnt_r == DivCntW'(DivSteps - 1)) begin
          state_nxt = ST_AX_MUL;
        end
      end
      ST_AX_MUL: state_nxt = ST_IDLE;
      ST_KEY_RD: state_nxt = ST_KEY_WR;
      ST_KEY_WR: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt     = idx_r;
    rd_ok_nxt   = rd_ok_r;
    vld_nxt     = vld_r;
    value_nxt   = value_r;
    span_nxt    = span_r;
    d_nxt       = d_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    dvd_nxt     = dvd_r;
    div_cnt_nxt = div_cnt_r;
    ram_we      = 1'b0;
    ram_wdata   = ChanLow;

    // the output register drains on its own; a tick load refills it
    out_valid_nxt = out_valid_r && out_stall;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          value_nxt = in_event_value;
          rd_ok_nxt = 1'b0;
          if (in_func) begin
            idx_nxt = '0;
          end else if (is_abs) begin
            idx_nxt = axis_of_code(in_event_code[2:0]);
          end else if (is_key) begin
            idx_nxt = btn.ch;
          end
        end
      end
      ST_TICK: begin
        if (tick_load) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = idx_r;
          out_value_nxt = rd_value;
          out_last_nxt  = (idx_r == LastChannel);
          idx_nxt       = idx_r + 1'b1;
          rd_ok_nxt     = 1'b0;
        end else begin
          // the registered read of the held address is ready once rd_ok_r is set
          rd_ok_nxt = 1'b1;
        end
      end
      ST_AX_PREP: begin
        span_nxt    = span_full[HalfW-1:0];
        d_nxt       = empty_rng ? '0 : d_full[HalfW-1:0];
        q_nxt       = '0;
        rem_nxt     = '0;
        dvd_nxt     = DivDividend;
        div_cnt_nxt = '0;
      end
      ST_AX_DIV: begin
        rem_nxt     = div_ge ? rem_sub[HalfW-1:0] : rem_sh[HalfW-1:0];
        q_nxt       = {q_r[DivSteps-2:0], div_ge};
        dvd_nxt     = {dvd_r[DivSteps-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 1'b1;
      end
      ST_AX_MUL: begin
        ram_we         = 1'b1;
        ram_wdata      = prod[ChanValW-1:0] + ChanLow;
        vld_nxt[idx_r] = 1'b1;
      end
      ST_KEY_RD: begin
        // channel read issued at idx_r, data lands next cycle
      end
      ST_KEY_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = (rd_value == ChanLow) ? ChanHigh : ChanLow;
        vld_nxt[idx_r] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      div_cnt_r   <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        range_r[i] <= RangeReset;
      end
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r     <= rd_ok_nxt;
      div_cnt_r   <= div_cnt_nxt;
      if (cfg_we && (cfg_index < CfgIdxW'(NumAxes))) begin
        range_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rd_vld_r    <= vld_r[idx_r];
    value_r     <= value_nxt;
    span_r      <= span_nxt;
    d_r         <= d_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    dvd_r       <= dvd_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  // channel value store
  ierc_ram #(
    .Width (ChanValW),
    .Depth (NumChannels)
  ) u_chan_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_index_r;
  assign out_channel_value = out_value_r;
  assign out_last_channel  = out_last_r;

  // a channel short of the last one means the tick is still running
  a_tick_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_index_r != LastChannel) |-> state_r == ST_TICK)
    else $error("tick ended before channel 15");

  // last flag marks channel 15 only
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_last_r == (out_index_r == LastChannel))
    else $error("last_channel out of step with channel index");

  // restoring divide keeps the remainder below the span
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_AX_DIV |-> rem_r < span_r)
    else $error("divider remainder out of range");

  // axis writes only land on axis channels
  a_axis_target: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_AX_MUL |-> idx_r < ChanIdxW'(NumAxes))
    else $error("axis result aimed at a button channel");

  // a key read is followed by its write, with requests still stalled
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEY_RD) |=> (state_r == ST_KEY_WR) && in_stall)
    else $error("key toggle sequence broken");

endmodule

`default_nettype wire

// File: hw/rtl/ierc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ierc_ram #(
  parameter int Width = 11,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
